/* design/ptc_pkg.sv */
// ptc_pkg: shared types and constants for the pressure/temperature compensation block
// no dependencies

package ptc_pkg;

  localparam int RawW  = 20;
  localparam int WordW = 32;
  localparam int CalW  = 48;
  localparam int DivW  = 32;

  // configuration register indexes
  localparam logic [1:0] RegTempCalib  = 2'd0;
  localparam logic [1:0] RegPressCalA  = 2'd1;
  localparam logic [1:0] RegPressCalB  = 2'd2;
  localparam logic [1:0] RegPressCalC  = 2'd3;

  // front-to-back request: pressure quotient inputs plus finished temperature
  typedef struct packed {
    logic [WordW-1:0] temp;
    logic [WordW-1:0] fine;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
    logic             pre_shift;  // dividend doubled before the divide
  } ptc_req_t;

  typedef struct packed {
    logic [WordW-1:0] temp;
    logic [WordW-1:0] fine;
    logic [WordW-1:0] press;
    logic             valid;
  } ptc_res_t;

  function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
    sx16 = {{(WordW-16){v[15]}}, v};
  endfunction

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x, input int n);
    asr = WordW'($signed(x) >>> n);
  endfunction

  function automatic logic [WordW-1:0] mul(input logic [WordW-1:0] a,
                                            input logic [WordW-1:0] b);
    logic [2*WordW-1:0] p;
    p = a * b;
    mul = p[WordW-1:0];
  endfunction

endpackage

/* design/ptc_front.sv */
// ptc_front: pipelined temperature path and pressure dividend/divisor preparation
// depends on ptc_pkg

module ptc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ptc_pkg::CalW-1:0]  temp_calib,
  input  logic [ptc_pkg::CalW-1:0]  press_calib_a,
  input  logic [ptc_pkg::CalW-1:0]  press_calib_b,
  input  logic                      in_valid,
  input  logic [ptc_pkg::RawW-1:0]  raw_pressure,
  input  logic [ptc_pkg::RawW-1:0]  raw_temperature,
  input  logic                      advance,
  output logic                      out_valid,
  output ptc_pkg::ptc_req_t         req
);
  localparam int W = ptc_pkg::WordW;
  localparam int NS = 7;

  logic [NS-1:0] vld;
  // per-stage registers
  logic [W-1:0] s1_a, s1_d, s1_p;           // stage 1
  logic [W-1:0] s2_a, s2_dd, s2_p;          // stage 2
  logic [W-1:0] s3_fine, s3_p;              // stage 3
  logic [W-1:0] s4_fine, s4_t5, s4_pa, s4_sq, s4_p;
  logic [W-1:0] s5_fine, s5_temp, s5_pa, s5_b, s5_a3, s5_a2, s5_p, s5_sq;
  logic [W-1:0] s6_fine, s6_temp, s6_b, s6_x, s6_p;
  logic [W-1:0] s7_fine, s7_temp, s7_div, s7_dvd;

  logic [W-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = {16'd0, temp_calib[15:0]};
  assign t2 = ptc_pkg::sx16(temp_calib[31:16]);
  assign t3 = ptc_pkg::sx16(temp_calib[47:32]);
  assign p1 = {16'd0, press_calib_a[15:0]};
  assign p2 = ptc_pkg::sx16(press_calib_a[31:16]);
  assign p3 = ptc_pkg::sx16(press_calib_a[47:32]);
  assign p4 = ptc_pkg::sx16(press_calib_b[15:0]);
  assign p5 = ptc_pkg::sx16(press_calib_b[31:16]);
  assign p6 = ptc_pkg::sx16(press_calib_b[47:32]);

  logic [W-1:0] adc_t, adc_p, fine3, pa4, sq4, b6, x6;
  logic [W-1:0] b7, a7, dvd_raw;
  assign adc_t = {{(W-ptc_pkg::RawW){1'b0}}, raw_temperature};
  assign adc_p = {{(W-ptc_pkg::RawW){1'b0}}, raw_pressure};
  assign fine3 = s2_a + ptc_pkg::asr(ptc_pkg::mul(s2_dd, t3), 14);
  assign pa4   = ptc_pkg::asr(s3_fine, 1) - 32'd64000;
  assign sq4   = ptc_pkg::mul(ptc_pkg::asr(pa4, 2), ptc_pkg::asr(pa4, 2));
  assign b6    = ptc_pkg::asr(s5_b + (s5_a2 << 1), 2) + (p4 << 16);
  assign x6    = ptc_pkg::asr(ptc_pkg::asr(s5_a3, 3) + ptc_pkg::asr(s5_pa, 1), 18);
  assign a7    = ptc_pkg::asr(ptc_pkg::mul(32'd32768 + s6_x, p1), 15);
  assign b7    = ptc_pkg::asr(s6_b, 12);
  assign dvd_raw = ptc_pkg::mul((32'd1048576 - s6_p) - b7, 32'd3125);

  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a <= (adc_t >> 3) - (t1 << 1);
      s1_d <= (adc_t >> 4) - t1;
      s1_p <= adc_p;
      s2_a  <= ptc_pkg::asr(ptc_pkg::mul(s1_a, t2), 11);
      s2_dd <= ptc_pkg::asr(ptc_pkg::mul(s1_d, s1_d), 12);
      s2_p  <= s1_p;
      s3_fine <= fine3;
      s3_p    <= s2_p;
      s4_fine <= s3_fine;
      s4_t5   <= ptc_pkg::mul(s3_fine, 32'd5) + 32'd128;
      s4_pa   <= pa4;
      s4_sq   <= sq4;
      s4_p    <= s3_p;
      s5_fine <= s4_fine;
      s5_temp <= ptc_pkg::asr(s4_t5, 8);
      s5_pa   <= ptc_pkg::mul(p2, s4_pa);
      s5_b    <= ptc_pkg::mul(ptc_pkg::asr(s4_sq, 11), p6);
      s5_a2   <= ptc_pkg::mul(s4_pa, p5);
      s5_a3   <= ptc_pkg::mul(p3, ptc_pkg::asr(s4_sq, 13));
      s5_sq   <= s4_sq;
      s5_p    <= s4_p;
      s6_fine <= s5_fine;
      s6_temp <= s5_temp;
      s6_b    <= b6;
      s6_x    <= x6;
      s6_p    <= s5_p;
      s7_fine <= s6_fine;
      s7_temp <= s6_temp;
      s7_div  <= a7;
      s7_dvd  <= dvd_raw;
    end
  end

  always_comb begin
    req.temp      = s7_temp;
    req.fine      = s7_fine;
    req.divisor   = s7_div;
    req.pre_shift = ~s7_dvd[W-1];
    req.dividend  = s7_dvd[W-1] ? s7_dvd : (s7_dvd << 1);
  end

  logic unused;
  assign unused = ^s5_sq;
endmodule

/* design/ptc_queue.sv */
// ptc_queue: short fifo between front and back sections
// depends on ptc_pkg

module ptc_queue #(
  parameter int Depth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ptc_pkg::ptc_req_t  push_data,
  input  logic               pop,
  output logic               not_empty,
  output ptc_pkg::ptc_req_t  pop_data,
  output logic [$clog2(Depth+1)-1:0] count
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  ptc_pkg::ptc_req_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;

  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

/* design/ptc_back.sv */
// ptc_back: pipelined restoring divider and final pressure correction
// depends on ptc_pkg

module ptc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ptc_pkg::CalW-1:0]  press_calib_c,
  input  logic                      in_valid,
  input  ptc_pkg::ptc_req_t         req,
  input  logic                      advance,
  output logic                      out_valid,
  output ptc_pkg::ptc_res_t         res
);
  localparam int W  = ptc_pkg::WordW;
  localparam int DS = 8;              // divider stages, 4 quotient bits each
  localparam int BPS = W / DS;
  localparam int NS = DS + 3;

  typedef struct packed {
    logic [W-1:0] temp;
    logic [W-1:0] fine;
    logic [W-1:0] num;   // remaining dividend bits, shifted left
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] div;
    logic         post;  // double after the divide
    logic         zero;
  } dstage_t;

  dstage_t dst [DS+1];
  logic [NS-1:0] vld;
  logic [W-1:0] p7, p8, p9;
  assign p7 = ptc_pkg::sx16(press_calib_c[15:0]);
  assign p8 = ptc_pkg::sx16(press_calib_c[31:16]);
  assign p9 = ptc_pkg::sx16(press_calib_c[47:32]);

  always_comb begin
    dst[0].temp = req.temp;
    dst[0].fine = req.fine;
    dst[0].num  = req.dividend;
    dst[0].rem  = '0;
    dst[0].quo  = '0;
    dst[0].div  = req.divisor;
    dst[0].post = ~req.pre_shift;
    dst[0].zero = req.divisor == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (advance) vld <= {vld[NS-2:0], in_valid};
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    dstage_t nx;
    always_comb begin
      logic [W:0] r;
      nx = dst[g];
      for (int k = 0; k < BPS; k++) begin
        r = {nx.rem, nx.num[W-1]};
        nx.num = nx.num << 1;
        if (r >= {1'b0, nx.div}) begin
          nx.rem = W'(r - {1'b0, nx.div});
          nx.quo = {nx.quo[W-2:0], 1'b1};
        end else begin
          nx.rem = r[W-1:0];
          nx.quo = {nx.quo[W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (advance) dst[g+1] <= nx;
    end
  end

  // correction stages
  logic [W-1:0] c1_p, c1_temp, c1_fine, c1_m1, c1_b;
  logic c1_zero;
  logic [W-1:0] c2_p, c2_temp, c2_fine, c2_a, c2_b;
  logic c2_zero;
  logic [W-1:0] c3_p, c3_temp, c3_fine;
  logic c3_zero;
  logic [W-1:0] q, qs;
  assign q  = dst[DS].post ? (dst[DS].quo << 1) : dst[DS].quo;
  assign qs = q >> 3;

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_p    <= q;
      c1_temp <= dst[DS].temp;
      c1_fine <= dst[DS].fine;
      c1_zero <= dst[DS].zero;
      c1_m1   <= ptc_pkg::mul(qs, qs) >> 13;
      c1_b    <= ptc_pkg::asr(ptc_pkg::mul(q >> 2, p8), 13);
      c2_p    <= c1_p;
      c2_temp <= c1_temp;
      c2_fine <= c1_fine;
      c2_zero <= c1_zero;
      c2_a    <= ptc_pkg::asr(ptc_pkg::mul(p9, c1_m1), 12);
      c2_b    <= c1_b;
      c3_temp <= c2_temp;
      c3_fine <= c2_fine;
      c3_zero <= c2_zero;
      c3_p    <= c2_zero ? '0 : c2_p + ptc_pkg::asr(c2_a + c2_b + p7, 4);
    end
  end

  assign out_valid = vld[NS-1];
  always_comb begin
    res.temp  = c3_temp;
    res.fine  = c3_fine;
    res.press = c3_p;
    res.valid = ~c3_zero;
  end
endmodule

/* design/pressure_temperature_compensation.sv */
// pressure_temperature_compensation: top level, config registers, front, queue, back, output
// depends on ptc_pkg, ptc_front, ptc_queue, ptc_back
//
// Takes one raw pressure/temperature request per cycle and returns one
// compensated result per request. Throughput is one request per clock while
// m_axis_tready stays high, as long as QueueDepth covers the front pipeline
// plus one entry (8 or more); a smaller queue caps the input rate through the
// credit check. A request passes the front pipeline (temperature and divisor
// multiplies), the queue, the back section (an 8-stage divider retiring 4
// quotient bits per stage, then the second-order correction) and the output
// register. Calibration words must be written through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce
// this. A zero divisor gives pressure 0 with pressure_valid low.

module pressure_temperature_compensation #(
  parameter int QueueDepth = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // temperature_centi, fine_temperature, pressure_pa
  output logic        m_axis_tuser    // pressure_valid
);
  localparam int CW = $clog2(QueueDepth+1);
  localparam int FrontLat = 7;
  localparam int BackLat  = 11;

  logic [47:0] temp_calib, press_calib_a, press_calib_b, press_calib_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::RegTempCalib: temp_calib    <= cfg_data;
        ptc_pkg::RegPressCalA: press_calib_a <= cfg_data;
        ptc_pkg::RegPressCalB: press_calib_b <= cfg_data;
        ptc_pkg::RegPressCalC: press_calib_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: free-running pipeline, never stalls; s_axis_tready drops when the queue could overflow
  logic front_adv, front_ov, q_pop, q_ne;
  logic [CW-1:0] q_count;
  ptc_pkg::ptc_req_t front_req, q_data;
  logic [FrontLat-1:0] front_busy;

  // credit: items in front pipeline plus queue must fit in the queue
  logic [$clog2(FrontLat+QueueDepth+2)-1:0] inflight;
  always_comb begin
    inflight = '0;
    for (int i = 0; i < FrontLat; i++) inflight = inflight + front_busy[i];
    inflight = inflight + q_count;
  end
  assign front_adv = 1'b1;
  assign s_axis_tready = inflight < QueueDepth + (q_pop ? 1 : 0);

  ptc_front u_front (
    .clk(clk), .rst(rst),
    .temp_calib(temp_calib), .press_calib_a(press_calib_a), .press_calib_b(press_calib_b),
    .in_valid(s_axis_tvalid && s_axis_tready),
    .raw_pressure(s_axis_tdata[19:0]), .raw_temperature(s_axis_tdata[39:20]),
    .advance(front_adv), .out_valid(front_ov), .req(front_req)
  );

  // mirror of front valid pipeline for credit counting
  always_ff @(posedge clk) begin
    if (rst) front_busy <= '0;
    else front_busy <= {front_busy[FrontLat-2:0], s_axis_tvalid && s_axis_tready};
  end

  ptc_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(front_ov), .push_data(front_req),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_data), .count(q_count)
  );

  // back: advances when the output register can take what falls out, or when nothing falls out
  logic back_adv, back_ov, out_load;
  ptc_pkg::ptc_res_t back_res;
  assign out_load = !m_axis_tvalid || m_axis_tready;
  assign back_adv = out_load || !back_ov;
  assign q_pop = q_ne && back_adv;

  ptc_back u_back (
    .clk(clk), .rst(rst), .press_calib_c(press_calib_c),
    .in_valid(q_pop), .req(q_data), .advance(back_adv),
    .out_valid(back_ov), .res(back_res)
  );

  // output register, holds its result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= back_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && back_ov) begin
      m_axis_tdata <= {back_res.press, back_res.fine, back_res.temp};
      m_axis_tuser <= back_res.valid;
    end
  end

  logic unused;
  assign unused = (BackLat == 0);
endmodule

/* design/ptc_checker.sv */
// ptc_checker: port-level assertions for pressure_temperature_compensation
// depends on pressure_temperature_compensation ports only

module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:64] == 32'd0)
    else $error("invalid pressure not zero");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
